/* hdl/assert_macros.svh */
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in base64 decoder");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition in base64 decoder");

`endif

/* hdl/b64d_pkg.sv */
// Types and constants shared by the base64 stream decoder modules.
package b64d_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned SymW  = 6;
  localparam int unsigned AccW  = 12;
  localparam int unsigned PendW = 3;

  localparam logic [CharW-1:0] LowerOfs  = 8'd26;
  localparam logic [CharW-1:0] DigitOfs  = 8'd52;
  localparam logic [SymW-1:0]  ValPlus   = 6'd62;
  localparam logic [SymW-1:0]  ValSlash  = 6'd63;
  localparam logic [PendW-1:0] PendFull  = 3'd6;
  localparam logic [PendW-1:0] PendStep  = 3'd2;

  typedef struct packed {
    logic [SymW-1:0] value;
    logic            skip;
    logic            bad;
  } sym_t;

endpackage

/* hdl/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder: one character in, one result out per transaction.
// Takes one character per cycle unless a result waits under out_stall_i, and returns exactly
// one result per character. An accepted character sits in the input register and is loaded
// into the result register when the result side advances; the result is presented from
// there. A new character may be accepted every cycle unless a result is stalled. While a
// result waits under out_stall_i, the result register holds and a full input register stalls
// the input side in the same cycle. The per-character work is a table lookup, a 6-bit shift
// into a 12-bit accumulator and a compare of the pending bit count, all between the input and
// result registers. Both standard and URL-safe alphabets decode; '=', LF, CR and space are
// skipped; any other byte flags the text as bad and suppresses bytes until the final
// character, whose result carries text_done and after which all state clears.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] text_char_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] out_byte_o,
  output logic             byte_valid_o,
  output logic             bad_text_o,
  output logic             text_done_o
);

  logic             advance;
  logic             stage_valid;
  logic [CharW-1:0] stage_char;
  logic             stage_last;
  sym_t             stage_sym;

  b64d_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_char_i (text_char_i),
    .last_char_i (last_char_i),
    .advance_i   (advance),
    .valid_o     (stage_valid),
    .char_o      (stage_char),
    .last_o      (stage_last)
  );

  b64d_classify u_classify (
    .text_char_i (stage_char),
    .sym_o       (stage_sym)
  );

  b64d_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stage_valid),
    .sym_i        (stage_sym),
    .last_i       (stage_last),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .bad_text_o   (bad_text_o),
    .text_done_o  (text_done_o)
  );

endmodule

/* hdl/b64d_classify.sv */
// Character classifier: maps one text byte to a 6-bit symbol, a skip or an error.
module b64d_classify import b64d_pkg::*; (
  input  logic [CharW-1:0] text_char_i,
  output sym_t             sym_o
);

  logic [CharW-1:0] upper_val;
  logic [CharW-1:0] lower_val;
  logic [CharW-1:0] digit_val;

  assign upper_val = text_char_i - 8'h41;
  assign lower_val = text_char_i - 8'h61 + LowerOfs;
  assign digit_val = text_char_i - 8'h30 + DigitOfs;

  always_comb begin
    sym_o = '{value: '0, skip: 1'b0, bad: 1'b0};
    unique case (text_char_i) inside
      [8'h41:8'h5a]: sym_o.value = upper_val[SymW-1:0];
      [8'h61:8'h7a]: sym_o.value = lower_val[SymW-1:0];
      [8'h30:8'h39]: sym_o.value = digit_val[SymW-1:0];
      8'h2b, 8'h2d:  sym_o.value = ValPlus;
      8'h2f, 8'h5f:  sym_o.value = ValSlash;
      8'h3d, 8'h0a, 8'h0d, 8'h20: sym_o.skip = 1'b1;
      default:       sym_o.bad = 1'b1;
    endcase
  end

endmodule

/* hdl/b64d_in_stage.sv */
// Input register stage: captures one character transaction and holds it while stalled.
module b64d_in_stage import b64d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] text_char_i,
  input  logic             last_char_i,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [CharW-1:0] char_o,
  output logic             last_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= text_char_i;
      last_q <= last_char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

/* hdl/b64d_pack.sv */
// Bit accumulator, error flag and result register of the decoder.
module b64d_pack import b64d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  sym_t             sym_i,
  input  logic             last_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] out_byte_o,
  output logic             byte_valid_o,
  output logic             bad_text_o,
  output logic             text_done_o
);

  `include "assert_macros.svh"

  logic [AccW-1:0]  acc_q, acc_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] byte_q, byte_d;
  logic             bvalid_q, bvalid_d;
  logic             bad_q, bad_d;
  logic             done_q;
  logic             fire;

  assign advance_o   = ~out_valid_q | ~out_stall_i;
  assign fire        = valid_i & advance_o;
  assign out_valid_d = advance_o ? valid_i : out_valid_q;

  always_comb begin
    logic [AccW-1:0] acc_sh;
    acc_sh   = {acc_q[AccW-SymW-1:0], sym_i.value};
    acc_d    = acc_q;
    pend_d   = pend_q;
    err_d    = err_q;
    byte_d   = '0;
    bvalid_d = 1'b0;
    if (!err_q) begin
      if (sym_i.bad) begin
        err_d = 1'b1;
      end else if (!sym_i.skip) begin
        acc_d = acc_sh;
        if (pend_q != '0) begin
          pend_d   = pend_q - PendStep;
          byte_d   = acc_sh[pend_d +: CharW];
          bvalid_d = 1'b1;
        end else begin
          pend_d = PendFull;
        end
      end
    end
    bad_d = err_d;
    if (last_i) begin
      acc_d  = '0;
      pend_d = '0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        err_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      bad_q    <= bad_d;
      done_q   <= last_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign bad_text_o   = bad_q;
  assign text_done_o  = done_q;

  `ASSERT_NEVER(a_pend_odd, clk_i, rst_ni, pend_q[0])
  `ASSERT_CLK(a_last_clears, clk_i, rst_ni,
    (fire && last_i) |=> (pend_q == '0 && !err_q && acc_q == '0))
  `ASSERT_CLK(a_err_sticky, clk_i, rst_ni,
    (fire && err_q && !last_i) |=> (err_q && bad_q && !bvalid_q))
  `ASSERT_CLK(a_zero_byte, clk_i, rst_ni,
    (out_valid_q && !bvalid_q) |-> (byte_q == '0))

endmodule

/* test/base64_stream_decoder_tb.sv */
// Self-checking testbench for the streaming base64 decoder: directed and random texts.
import b64d_pkg::*;

typedef enum logic [1:0] {SymData, SymSkip, SymBad} sym_kind_e;

typedef struct packed {
  logic [CharW-1:0] out_byte;
  logic             byte_valid;
  logic             bad_text;
  logic             text_done;
} dec_result_t;

class decode_scoreboard;
  logic [AccW-1:0]  acc_bits;
  logic [PendW-1:0] held_count;
  logic             text_bad;
  dec_result_t      pending_results[$];
  int               mismatches;
  int               sent;
  int               consumed;
  int               texts;
  int               bad_texts;
  int               bytes_out;

  function new();
    acc_bits   = '0;
    held_count = '0;
    text_bad   = 1'b0;
    mismatches = 0;
    sent       = 0;
    consumed   = 0;
    texts      = 0;
    bad_texts  = 0;
    bytes_out  = 0;
  endfunction

  function sym_kind_e classify(input logic [CharW-1:0] c, output logic [SymW-1:0] v);
    v = '0;
    if (c >= "A" && c <= "Z") begin
      v = SymW'(c - "A");
      return SymData;
    end
    if (c >= "a" && c <= "z") begin
      v = SymW'(c - "a" + LowerOfs);
      return SymData;
    end
    if (c >= "0" && c <= "9") begin
      v = SymW'(c - "0" + DigitOfs);
      return SymData;
    end
    if (c == "+" || c == "-") begin
      v = ValPlus;
      return SymData;
    end
    if (c == "/" || c == "_") begin
      v = ValSlash;
      return SymData;
    end
    if (c == "=" || c == "\n" || c == "\r" || c == " ") return SymSkip;
    return SymBad;
  endfunction

  function void note_char(input logic [CharW-1:0] c, input logic last);
    dec_result_t      r;
    logic [SymW-1:0]  v;
    logic [PendW:0]   cnt;
    sym_kind_e        kind;
    r = '0;
    sent++;
    if (!text_bad) begin
      kind = classify(c, v);
      if (kind != SymSkip) consumed++;
      if (kind == SymBad) begin
        text_bad = 1'b1;
      end else if (kind == SymData) begin
        acc_bits = {acc_bits[AccW-SymW-1:0], v};
        cnt = {1'b0, held_count} + (PendW+1)'(6);
        if (cnt >= (PendW+1)'(8)) begin
          cnt = cnt - (PendW+1)'(8);
          r.out_byte   = CharW'(acc_bits >> cnt);
          r.byte_valid = 1'b1;
          bytes_out++;
        end
        held_count = cnt[PendW-1:0];
      end
    end
    r.bad_text  = text_bad;
    r.text_done = last;
    pending_results = {pending_results, r};
    if (last) begin
      texts++;
      if (text_bad) bad_texts++;
      acc_bits   = '0;
      held_count = '0;
      text_bad   = 1'b0;
    end
  endfunction

  function void check_result(input dec_result_t got);
    dec_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: byte %02h valid %0b bad %0b done %0b",
                 got.out_byte, got.byte_valid, got.bad_text, got.text_done);
      return;
    end
    want = pending_results.pop_front();
    if (got.out_byte != want.out_byte || got.byte_valid != want.byte_valid ||
        got.bad_text != want.bad_text || got.text_done != want.text_done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected byte %02h valid %0b bad %0b done %0b, got %02h %0b %0b %0b",
                 want.out_byte, want.byte_valid, want.bad_text, want.text_done,
                 got.out_byte, got.byte_valid, got.bad_text, got.text_done);
    end
  endfunction

  function int waiting();
    return pending_results.size();
  endfunction

  function void close_out();
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
  endfunction
endclass

module base64_stream_decoder_tb;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 1800;
  localparam int MaxGap     = 12;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CharW-1:0] text_char_i;
  logic             last_char_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [CharW-1:0] out_byte_o;
  logic             byte_valid_o;
  logic             bad_text_o;
  logic             text_done_o;

  decode_scoreboard sb;
  int               cycles = 0;
  bit               tx_calm = 1'b0;
  bit               rx_calm = 1'b0;

  base64_stream_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_char_i  (text_char_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .bad_text_o   (bad_text_o),
    .text_done_o  (text_done_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.waiting());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({out_byte_o, byte_valid_o, bad_text_o, text_done_o});
  end

  // pace the result side
  initial begin
    int n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = rx_calm ? 0 : $urandom_range(0, MaxGap);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_char(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // hold off the sender until every outstanding transaction has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] sym_char(input int v, input bit url);
    if (v < LowerOfs) return CharW'("A" + v);
    if (v < DigitOfs) return CharW'("a" + v - LowerOfs);
    if (v < ValPlus) return CharW'("0" + v - DigitOfs);
    if (v == ValPlus) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  task automatic send_random_text();
    int               len;
    int               r;
    bit               noisy;
    bit               url;
    string            skips;
    logic [CharW-1:0] c;
    skips = "=\n\r ";
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    noisy = ($urandom_range(0, 4) == 0);
    url   = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (noisy && r < 15)
        c = CharW'($urandom_range(0, 255));
      else if (r >= 90)
        c = skips[$urandom_range(0, 3)];
      else
        c = sym_char($urandom_range(0, 63), url ^ ($urandom_range(0, 9) == 0));
      send_char(c, i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    text_char_i <= '0;
    last_char_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("TWFu");
    send_text("az09-_+/\r\n =");
    send_char(8'h00, 1'b0);
    send_char("Q", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h80, 1'b1);
    send_char(8'h7f, 1'b1);
    send_text("QQ");
    drain_results();

    while (sb.sent < ItemTarget) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      send_random_text();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
    repeat (8) @(posedge clk_i);
    sb.close_out();

    $display("covered %0d texts (%0d flagged bad), %0d characters sent, %0d bytes out",
             sb.texts, sb.bad_texts, sb.sent, sb.bytes_out);
    $display("with random stalls on both sides, %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
